// File: design/ecpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpr_pkg
// Shared codes, constants and controller/datapath interface types for the
// ECP radial potential evaluator.
// ----------------------------------------------------------------------------
package ecpr_pkg;

  // Operation codes carried on the input tuser.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_EVAL  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // Multiplier operations: operand pair, shift and destination register.
  localparam logic [2:0] MO_R2   = 3'd0;
  localparam logic [2:0] MO_POW  = 3'd1;
  localparam logic [2:0] MO_XQ   = 3'd2;
  localparam logic [2:0] MO_T    = 3'd3;
  localparam logic [2:0] MO_Y    = 3'd4;
  localparam logic [2:0] MO_TERM = 3'd5;
  localparam logic [2:0] MO_PE   = 3'd6;
  localparam logic [2:0] MO_MAG  = 3'd7;

  // Divider operations.
  localparam logic DV_BASE = 1'b0;
  localparam logic DV_TERM = 1'b1;

  // Rounding shift amounts of the products.
  localparam logic [5:0] SH_R2   = 6'd0;
  localparam logic [5:0] SH_MAG  = 6'd8;
  localparam logic [5:0] SH_POW  = 6'd24;
  localparam logic [5:0] SH_XQ   = 6'd32;
  localparam logic [5:0] SH_Y    = 6'd34;
  localparam logic [5:0] SH_T    = 6'd60;
  localparam logic [5:0] SH_Q62  = 6'd62;

  // Fixed-point constants.
  localparam logic [63:0] LOG2E_Q60 = 64'h1715_4765_2B82_FE17;
  localparam logic [63:0] LN2_Q64   = 64'hB172_17F7_D1CF_79AC;
  localparam logic [63:0] ONE_Q62   = 64'h4000_0000_0000_0000;
  localparam logic [63:0] ONE_Q24   = 64'h0000_0000_0100_0000;
  localparam logic [63:0] TERM_CAP  = 64'h0010_0000_0000_0000;
  localparam logic [63:0] BASE_NUM  = 64'h0001_0000_0000_0000;
  localparam logic [47:0] POT_MAX   = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] POT_MIN   = 48'h8000_0000_0000;
  localparam logic [4:0]  SERIES_LEN = 5'd20;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       write_prim;
    logic       clear_tbl;
    logic       set_full;
    logic       eval_init;
    logic       idx_inc;
    logic       add_cap;
    logic       pow_prep;
    logic       pcnt_dec;
    logic       mul_start;
    logic [2:0] mul_op;
    logic       div_start;
    logic       div_sel;
    logic       e_zero;
    logic       series_init;
    logic       e_final;
    logic       add_term;
    logic       eval_done;
    logic       out_load;
  } ecpr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       more;
    logic       ang_match;
    logic       r_zero;
    logic       p_neg;
    logic       p_zero;
    logic       pcnt_zero;
    logic       pw_sat;
    logic       xq_big;
    logic       series_last;
    logic       mul_done;
    logic       div_done;
  } ecpr_stat_t;

endpackage

// File: design/ecpr_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpr_mul
// Shared 64x64 multiplier with round-half-up right shift and overflow
// saturation, built from four 32x32 partial products over several cycles.
// ----------------------------------------------------------------------------
module ecpr_mul
  import ecpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic [5:0]  shift,
  output logic        done,
  output logic [63:0] res,
  output logic        ovf
);

  logic         busy_r;
  logic [2:0]   step_r;
  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [5:0]   sh_r;
  logic [127:0] acc_r;
  logic [63:0]  pp_r;
  logic [1:0]   off_r;
  logic [63:0]  res_r;
  logic         ovf_r;
  logic         done_r;

  logic [31:0]  a_half;
  logic [31:0]  b_half;
  logic [127:0] pp_shifted;
  logic [127:0] rnd;
  logic [127:0] hi;

  // Partial product selection and alignment.
  assign a_half     = step_r[0] ? a_r[63:32] : a_r[31:0];
  assign b_half     = step_r[1] ? b_r[63:32] : b_r[31:0];
  assign pp_shifted = {64'd0, pp_r} << {off_r, 5'd0};
  assign rnd        = (sh_r == 6'd0) ? 128'd0 : (128'd1 << (sh_r - 6'd1));
  assign hi         = acc_r >> sh_r;

  // Control of the step sequence.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 3'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 3'd0;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == 3'd6) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath of the multiplier.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      sh_r  <= shift;
      acc_r <= 128'd0;
    end else if (busy_r) begin
      if (step_r < 3'd4) begin
        pp_r  <= a_half * b_half;
        off_r <= {1'b0, step_r[0]} + {1'b0, step_r[1]};
      end
      if (step_r >= 3'd1 && step_r <= 3'd4) begin
        acc_r <= acc_r + pp_shifted;
      end
      if (step_r == 3'd5) begin
        acc_r <= acc_r + rnd;
      end
      if (step_r == 3'd6) begin
        ovf_r <= |hi[127:64];
        res_r <= (|hi[127:64]) ? {64{1'b1}} : hi[63:0];
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;
  assign ovf  = ovf_r;

endmodule

// File: design/ecpr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpr_div
// Shared restoring divider: 64-bit dividend by 32-bit divisor, one quotient
// bit per cycle, truncating.
// ----------------------------------------------------------------------------
module ecpr_div
  import ecpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quot
);

  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [63:0] quo_r;
  logic [31:0] rem_r;
  logic [31:0] d_r;
  logic        done_r;

  logic [32:0] trial;
  logic        fits;
  logic [32:0] diff;

  // One restoring step.
  assign trial = {rem_r, quo_r[63]};
  assign fits  = trial >= {1'b0, d_r};
  assign diff  = trial - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 6'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= 32'd0;
      d_r   <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[31:0] : trial[31:0];
      quo_r <= {quo_r[62:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

// File: design/ecpr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpr_dp
// Datapath: primitive table, input capture, power, exponential and
// accumulation registers around the shared multiplier and divider.
// ----------------------------------------------------------------------------
module ecpr_dp
  import ecpr_pkg::*;
#(
  parameter int MAX_PRIMS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [103:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  ecpr_cmd_t    cmd,
  output ecpr_stat_t   st,
  output logic [55:0]  out_tdata,
  output logic [1:0]   out_tuser
);

  localparam int CW    = $clog2(MAX_PRIMS + 1);
  localparam int AW    = (MAX_PRIMS > 1) ? $clog2(MAX_PRIMS) : 1;
  localparam int ENT_W = 71;

  // Captured input beat.
  logic [1:0]  op_r;
  logic [31:0] rad_r;
  logic [2:0]  ang_r;
  logic [2:0]  rawp_r;
  logic [31:0] exp_in_r;
  logic [31:0] coef_in_r;

  // Table state.
  logic [ENT_W-1:0] mem [MAX_PRIMS];
  logic [ENT_W-1:0] rd_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    idx_r;
  logic [2:0]       top_r;

  // Evaluation registers.
  logic [63:0] r2_r;
  logic [63:0] base_r;
  logic [63:0] pw_r;
  logic [2:0]  pcnt_r;
  logic [63:0] xq_r;
  logic        xq_ovf_r;
  logic [63:0] t_r;
  logic [63:0] y_r;
  logic [63:0] term_r;
  logic [63:0] esum_r;
  logic [4:0]  n_r;
  logic [63:0] e_r;
  logic [63:0] pe_r;
  logic [63:0] mag_r;
  logic        mag_ovf_r;
  logic [63:0] sum_r;
  logic        capped_r;
  logic [47:0] res_pot_r;
  logic [1:0]  res_st_r;
  logic [2:0]  mop_r;
  logic        dsel_r;

  // Output beat.
  logic [47:0] out_pot_r;
  logic [1:0]  out_st_r;
  logic [2:0]  out_top_r;

  // Entry fields and derived values.
  logic [2:0]        ent_ang;
  logic signed [3:0] ent_pow;
  logic [31:0]       ent_exp;
  logic [31:0]       ent_coef;
  logic              coef_neg;
  logic [32:0]       dmag;
  logic [3:0]        pow_in;
  logic              term_cap;
  logic [63:0]       term_val;
  logic              in_range;

  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic [5:0]  mul_sh;
  logic        mul_done;
  logic [63:0] mul_res;
  logic        mul_ovf;
  logic [63:0] div_num;
  logic [31:0] div_den;
  logic        div_done;
  logic [63:0] div_q;

  assign ent_ang  = rd_r[2:0];
  assign ent_pow  = signed'(rd_r[6:3]);
  assign ent_exp  = rd_r[38:7];
  assign ent_coef = rd_r[70:39];
  assign coef_neg = ent_coef[31];
  assign dmag     = coef_neg ? (33'h1_0000_0000 - {1'b0, ent_coef}) : {1'b0, ent_coef};
  assign pow_in   = {1'b0, rawp_r} - 4'd2;

  // Term capping and sign.
  assign term_cap = mag_ovf_r || (|mag_r[63:52]);
  assign term_val = term_cap ? (coef_neg ? -TERM_CAP : TERM_CAP)
                             : (coef_neg ? -mag_r : mag_r);
  assign in_range = (&sum_r[63:47]) || !(|sum_r[63:47]);

  // Multiplier operand selection.
  always_comb begin
    mul_a  = pw_r;
    mul_b  = base_r;
    mul_sh = SH_POW;
    case (cmd.mul_op)
      MO_R2: begin
        mul_a  = {32'd0, rad_r};
        mul_b  = {32'd0, rad_r};
        mul_sh = SH_R2;
      end
      MO_POW: begin
        mul_a  = pw_r;
        mul_b  = base_r;
        mul_sh = SH_POW;
      end
      MO_XQ: begin
        mul_a  = {32'd0, ent_exp};
        mul_b  = r2_r;
        mul_sh = SH_XQ;
      end
      MO_T: begin
        mul_a  = xq_r;
        mul_b  = LOG2E_Q60;
        mul_sh = SH_T;
      end
      MO_Y: begin
        mul_a  = {32'd0, t_r[31:0]};
        mul_b  = LN2_Q64;
        mul_sh = SH_Y;
      end
      MO_TERM: begin
        mul_a  = term_r;
        mul_b  = y_r;
        mul_sh = SH_Q62;
      end
      MO_PE: begin
        mul_a  = pw_r;
        mul_b  = e_r;
        mul_sh = SH_Q62;
      end
      MO_MAG: begin
        mul_a  = pe_r;
        mul_b  = {31'd0, dmag};
        mul_sh = SH_MAG;
      end
      default: begin
        mul_a  = pw_r;
        mul_b  = base_r;
        mul_sh = SH_POW;
      end
    endcase
  end

  // Divider operand selection.
  assign div_num = (cmd.div_sel == DV_BASE) ? (BASE_NUM + {33'd0, rad_r[31:1]}) : term_r;
  assign div_den = (cmd.div_sel == DV_BASE) ? rad_r : {27'd0, n_r};

  ecpr_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .shift (mul_sh),
    .done  (mul_done),
    .res   (mul_res),
    .ovf   (mul_ovf)
  );

  ecpr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quot     (div_q)
  );

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.write_prim) begin
      mem[count_r[AW-1:0]] <= {coef_in_r, exp_in_r, pow_in, ang_r};
    end
    rd_r <= mem[idx_r[AW-1:0]];
  end

  // Table control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      top_r   <= 3'd0;
      idx_r   <= '0;
    end else begin
      if (cmd.write_prim) begin
        count_r <= count_r + 1'b1;
        if (ang_r > top_r) begin
          top_r <= ang_r;
        end
      end
      if (cmd.clear_tbl) begin
        count_r <= '0;
        top_r   <= 3'd0;
      end
      if (cmd.eval_init) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // Input capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= in_tuser;
      rad_r     <= in_tdata[31:0];
      ang_r     <= in_tdata[34:32];
      rawp_r    <= in_tdata[37:35];
      exp_in_r  <= in_tdata[69:38];
      coef_in_r <= in_tdata[101:70];
    end
  end

  // Arithmetic registers of the evaluation.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_pot_r <= 48'd0;
      res_st_r  <= ST_OK;
    end
    if (cmd.set_full) begin
      res_st_r <= ST_FULL;
    end
    if (cmd.eval_init) begin
      sum_r    <= 64'd0;
      capped_r <= 1'b0;
    end
    if (cmd.mul_start) begin
      mop_r <= cmd.mul_op;
    end
    if (cmd.div_start) begin
      dsel_r <= cmd.div_sel;
    end

    // Power setup from the current entry.
    if (cmd.pow_prep) begin
      pcnt_r <= ent_pow[3] ? (3'(-ent_pow) - 3'd1) : (ent_pow[2:0] - 3'd1);
      if (ent_pow == 4'sd0) begin
        pw_r <= ONE_Q24;
      end else if (!ent_pow[3]) begin
        base_r <= {32'd0, rad_r};
        pw_r   <= {32'd0, rad_r};
      end
    end
    if (cmd.pcnt_dec) begin
      pcnt_r <= pcnt_r - 3'd1;
    end

    // Multiplier results go to the register named by the operation.
    if (mul_done) begin
      case (mop_r)
        MO_R2:   r2_r <= mul_res;
        MO_POW:  pw_r <= mul_res;
        MO_XQ: begin
          xq_r     <= mul_res;
          xq_ovf_r <= mul_ovf;
        end
        MO_T:    t_r    <= mul_res;
        MO_Y:    y_r    <= mul_res;
        MO_TERM: term_r <= mul_res;
        MO_PE:   pe_r   <= mul_res;
        MO_MAG: begin
          mag_r     <= mul_res;
          mag_ovf_r <= mul_ovf;
        end
        default: pw_r <= mul_res;
      endcase
    end

    // Divider results: reciprocal base or next series term.
    if (div_done) begin
      if (dsel_r == DV_BASE) begin
        base_r <= div_q;
        pw_r   <= div_q;
      end else begin
        term_r <= div_q;
        esum_r <= n_r[0] ? (esum_r - div_q) : (esum_r + div_q);
        n_r    <= n_r + 5'd1;
      end
    end

    // Exponential series.
    if (cmd.series_init) begin
      term_r <= ONE_Q62;
      esum_r <= ONE_Q62;
      n_r    <= 5'd1;
    end
    if (cmd.e_zero) begin
      e_r <= 64'd0;
    end
    if (cmd.e_final) begin
      if ((|t_r[63:38]) || (t_r[37:32] == 6'd63)) begin
        e_r <= 64'd0;
      end else begin
        e_r <= esum_r >> t_r[37:32];
      end
    end

    // Accumulation.
    if (cmd.add_cap) begin
      sum_r    <= sum_r + (coef_neg ? -TERM_CAP : TERM_CAP);
      capped_r <= 1'b1;
    end
    if (cmd.add_term) begin
      sum_r <= sum_r + term_val;
      if (term_cap) begin
        capped_r <= 1'b1;
      end
    end
    if (cmd.eval_done) begin
      if (capped_r || !in_range) begin
        res_pot_r <= sum_r[63] ? POT_MIN : POT_MAX;
        res_st_r  <= ST_SAT;
      end else begin
        res_pot_r <= sum_r[47:0];
      end
    end

    // Output beat.
    if (cmd.out_load) begin
      out_pot_r <= res_pot_r;
      out_st_r  <= res_st_r;
      out_top_r <= top_r;
    end
  end

  // Status toward the controller.
  always_comb begin
    st.op          = op_r;
    st.full        = count_r >= CW'(MAX_PRIMS);
    st.more        = idx_r < count_r;
    st.ang_match   = ent_ang == ang_r;
    st.r_zero      = rad_r == 32'd0;
    st.p_neg       = ent_pow[3];
    st.p_zero      = ent_pow == 4'sd0;
    st.pcnt_zero   = pcnt_r == 3'd0;
    st.pw_sat      = &pw_r;
    st.xq_big      = xq_ovf_r || (|xq_r[63:38]);
    st.series_last = n_r == SERIES_LEN;
    st.mul_done    = mul_done;
    st.div_done    = div_done;
  end

  assign out_tdata = {5'd0, out_top_r, out_pot_r};
  assign out_tuser = out_st_r;

endmodule

// File: design/ecpr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpr_ctrl
// Controller: sequences loads, clears and the per-primitive evaluation on
// the shared multiplier and divider, and owns the stream handshakes.
// ----------------------------------------------------------------------------
module ecpr_ctrl
  import ecpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  ecpr_stat_t st,
  output ecpr_cmd_t  cmd
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DECODE  = 5'd1;
  localparam logic [4:0] S_R2      = 5'd2;
  localparam logic [4:0] S_FETCH   = 5'd3;
  localparam logic [4:0] S_READ    = 5'd4;
  localparam logic [4:0] S_DIVB    = 5'd5;
  localparam logic [4:0] S_POWLOOP = 5'd6;
  localparam logic [4:0] S_MULPOW  = 5'd7;
  localparam logic [4:0] S_XQ      = 5'd8;
  localparam logic [4:0] S_XQCHK   = 5'd9;
  localparam logic [4:0] S_T       = 5'd10;
  localparam logic [4:0] S_Y       = 5'd11;
  localparam logic [4:0] S_SERINIT = 5'd12;
  localparam logic [4:0] S_TMUL    = 5'd13;
  localparam logic [4:0] S_TDIV    = 5'd14;
  localparam logic [4:0] S_EFIN    = 5'd15;
  localparam logic [4:0] S_PE      = 5'd16;
  localparam logic [4:0] S_MAG     = 5'd17;
  localparam logic [4:0] S_ADD     = 5'd18;
  localparam logic [4:0] S_NEXT    = 5'd19;
  localparam logic [4:0] S_FINAL   = 5'd20;
  localparam logic [4:0] S_FINISH  = 5'd21;

  logic [4:0] state_r;
  logic [4:0] state_nxt;
  logic       go_r;
  logic       go_nxt;
  logic       ovalid_r;
  logic       ovalid_nxt;
  logic       out_free;

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = ovalid_r;
  assign out_free   = !ovalid_r || out_tready;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FINISH;
        if (st.op == OP_LOAD) begin
          if (st.full) begin
            cmd.set_full = 1'b1;
          end else begin
            cmd.write_prim = 1'b1;
          end
        end else if (st.op == OP_EVAL) begin
          cmd.eval_init = 1'b1;
          state_nxt     = S_R2;
        end else if (st.op == OP_CLEAR) begin
          cmd.clear_tbl = 1'b1;
        end
      end
      S_R2: begin
        cmd.mul_op    = MO_R2;
        cmd.mul_start = !go_r;
        if (st.mul_done) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        state_nxt = st.more ? S_READ : S_FINAL;
      end
      S_READ: begin
        // Skip entries of other angular momentum; zero radius with a
        // negative power is a capped term.
        if (!st.ang_match) begin
          state_nxt = S_NEXT;
        end else if (st.r_zero && st.p_neg) begin
          cmd.add_cap = 1'b1;
          state_nxt   = S_NEXT;
        end else begin
          cmd.pow_prep = 1'b1;
          if (st.p_zero) begin
            state_nxt = S_XQ;
          end else if (st.p_neg) begin
            state_nxt = S_DIVB;
          end else begin
            state_nxt = S_POWLOOP;
          end
        end
      end
      S_DIVB: begin
        cmd.div_sel   = DV_BASE;
        cmd.div_start = !go_r;
        if (st.div_done) begin
          state_nxt = S_POWLOOP;
        end
      end
      S_POWLOOP: begin
        if (st.pcnt_zero) begin
          state_nxt = S_XQ;
        end else if (st.pw_sat) begin
          cmd.pcnt_dec = 1'b1;
        end else begin
          state_nxt = S_MULPOW;
        end
      end
      S_MULPOW: begin
        cmd.mul_op    = MO_POW;
        cmd.mul_start = !go_r;
        if (st.mul_done) begin
          cmd.pcnt_dec = 1'b1;
          state_nxt    = S_POWLOOP;
        end
      end
      S_XQ: begin
        cmd.mul_op    = MO_XQ;
        cmd.mul_start = !go_r;
        if (st.mul_done) begin
          state_nxt = S_XQCHK;
        end
      end
      S_XQCHK: begin
        if (st.xq_big) begin
          cmd.e_zero = 1'b1;
          state_nxt  = S_PE;
        end else begin
          state_nxt = S_T;
        end
      end
      S_T: begin
        cmd.mul_op    = MO_T;
        cmd.mul_start = !go_r;
        if (st.mul_done) begin
          state_nxt = S_Y;
        end
      end
      S_Y: begin
        cmd.mul_op    = MO_Y;
        cmd.mul_start = !go_r;
        if (st.mul_done) begin
          state_nxt = S_SERINIT;
        end
      end
      S_SERINIT: begin
        cmd.series_init = 1'b1;
        state_nxt       = S_TMUL;
      end
      S_TMUL: begin
        cmd.mul_op    = MO_TERM;
        cmd.mul_start = !go_r;
        if (st.mul_done) begin
          state_nxt = S_TDIV;
        end
      end
      S_TDIV: begin
        cmd.div_sel   = DV_TERM;
        cmd.div_start = !go_r;
        if (st.div_done) begin
          state_nxt = st.series_last ? S_EFIN : S_TMUL;
        end
      end
      S_EFIN: begin
        cmd.e_final = 1'b1;
        state_nxt   = S_PE;
      end
      S_PE: begin
        cmd.mul_op    = MO_PE;
        cmd.mul_start = !go_r;
        if (st.mul_done) begin
          state_nxt = S_MAG;
        end
      end
      S_MAG: begin
        cmd.mul_op    = MO_MAG;
        cmd.mul_start = !go_r;
        if (st.mul_done) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add_term = 1'b1;
        state_nxt    = S_NEXT;
      end
      S_NEXT: begin
        cmd.idx_inc = 1'b1;
        state_nxt   = S_FETCH;
      end
      S_FINAL: begin
        cmd.eval_done = 1'b1;
        state_nxt     = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Unit handshake flag and output valid.
  always_comb begin
    go_nxt = go_r;
    if (cmd.mul_start || cmd.div_start) begin
      go_nxt = 1'b1;
    end else if (st.mul_done || st.div_done) begin
      go_nxt = 1'b0;
    end
    ovalid_nxt = ovalid_r;
    if (cmd.out_load) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      go_r     <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      go_r     <= go_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

// File: design/ecp_radial_potential_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecp_radial_potential_eval
// Table of Gaussian ECP primitives with fixed-point evaluation of the
// radial potential sum for a given radius and angular momentum.
// ----------------------------------------------------------------------------
// One beat is handled at a time. Load, clear and unused op codes go from the
// decode state straight to the finish state. An evaluate squares the radius
// and then visits each table entry in turn: an entry of another angular
// momentum is skipped, a matching entry with zero radius and a negative
// power adds a capped term, and every other matching entry is evaluated in
// full. The twenty-term exponential series dominates: each term runs one
// product on the shared multiplier and one quotient on the bit-serial
// divider. Each extra power step adds a product, a negative power adds a
// division for the reciprocal base, and an exponent product that is too
// large skips the series. A finished result sits in the output register
// while the next input beat is accepted; a new result waits in the finish
// state while the output register still holds a beat that is not taken.
module ecp_radial_potential_eval
  import ecpr_pkg::*;
#(
  parameter int MAX_PRIMS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] radius, [34:32] ang_mom, [37:35] raw_power,
  // [69:38] gauss_exponent, [101:70] gauss_coeff, [103:102] zero
  input  logic [103:0] in_tdata,
  // [1:0] op
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [47:0] potential, [50:48] max_ang_mom, [55:51] zero
  output logic [55:0]  out_tdata,
  // [1:0] status
  output logic [1:0]   out_tuser
);

  ecpr_cmd_t  cmd;
  ecpr_stat_t st;

  ecpr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  ecpr_dp #(
    .MAX_PRIMS (MAX_PRIMS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .st        (st),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
